/* rtl/sorted_key_value_table_core_assert.svh */
// Assertion macros for the sorted key/value table core.
// Used by the top level only; needs nothing else.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key/value table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key/value table: next-cycle check failed");

`endif

/* rtl/skvt_pkg.sv */
// Shared types and constants of the sorted key/value table core.
// No dependencies; every other file but the assertion header imports it.
package skvt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int WORD_BITS       = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

endpackage

/* rtl/skvt_if.sv */
// Request and response channel interfaces of the sorted key/value table core.
// Depends on skvt_pkg.
interface skvt_req_if
    import skvt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int POS_BITS = 6
);
    logic                 valid;
    logic                 ready;
    op_t                  opcode;
    logic [KEY_BITS-1:0]  row_key;
    logic [WORD_BITS-1:0] data_word;
    logic [POS_BITS-1:0]  position;

    modport source (output valid, opcode, row_key, data_word, position, input ready);
    modport sink   (input valid, opcode, row_key, data_word, position, output ready);
endinterface

interface skvt_rsp_if
    import skvt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int CNT_BITS = 7
);
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [KEY_BITS-1:0]  entry_key;
    logic [WORD_BITS-1:0] entry_word;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 overflow;

    modport source (output valid, found, entry_key, entry_word, entry_count, overflow,
                    input ready);
    modport sink   (input valid, found, entry_key, entry_word, entry_count, overflow,
                    output ready);
endinterface

/* rtl/skvt_cell.sv */
// One entry cell of the sorted table chain: holds a key and a value word.
// Depends on skvt_pkg; instantiated in a row by the top level.
module skvt_cell
    import skvt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 clk,
    input  cell_ctrl_t           ctl,
    input  logic                 occ,
    input  logic                 tail,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic [WORD_BITS-1:0] new_word,
    input  logic                 left_sel,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [KEY_BITS-1:0]  right_key,
    input  logic [WORD_BITS-1:0] right_word,
    output logic                 sel,
    output logic [KEY_BITS-1:0]  key,
    output logic [WORD_BITS-1:0] word
);

    logic [KEY_BITS-1:0]  key_reg,  key_next;
    logic [WORD_BITS-1:0] word_reg, word_next;

    // The cell moves on an insert when the new key goes here or further left.
    assign sel = tail || (occ && (new_key < key_reg));

    always_comb
    begin
        key_next  = key_reg;
        word_next = word_reg;
        if (ctl.rotate)
        begin
            key_next  = right_key;
            word_next = right_word;
        end
        else if (ctl.insert && sel)
        begin
            if (left_sel)
            begin
                key_next  = left_key;
                word_next = left_word;
            end
            else
            begin
                key_next  = new_key;
                word_next = new_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        word_reg <= word_next;
    end

    assign key  = key_reg;
    assign word = word_reg;

endmodule

/* rtl/skvt_ctrl.sv */
// Sequencer of the sorted table: request handshake, fill count, ring scan
// for lookups and reads, and the response register. Depends on skvt_pkg, skvt_if.
module skvt_ctrl
    import skvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    skvt_req_if.sink                            req,
    skvt_rsp_if.source                          rsp,
    input  logic [KEY_BITS-1:0]                 head_key,
    input  logic [WORD_BITS-1:0]                head_word,
    output cell_ctrl_t                          ctl,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    count
);

    localparam int POS_BITS = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam logic [POS_BITS-1:0] LAST_STEP = POS_BITS'(TABLE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(TABLE_DEPTH);

    state_t               state_reg, state_next;
    logic [POS_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    op_t                  op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic                 hit_reg, hit_next;
    logic [KEY_BITS-1:0]  rd_key_reg, rd_key_next;
    logic [WORD_BITS-1:0] rd_word_reg, rd_word_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [KEY_BITS-1:0]  out_key_reg, out_key_next;
    logic [WORD_BITS-1:0] out_word_reg, out_word_next;
    logic [CNT_BITS-1:0]  out_count_reg, out_count_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic out_free;
    logic accept;
    logic full;
    logic scan_op;
    logic load_now;
    logic load_finish;
    logic step_live;

    assign full     = (count_reg == FULL_CNT);
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;
    assign scan_op  = (req.opcode == OP_LOOKUP) || (req.opcode == OP_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && scan_op)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE) && out_free;
        ctl.insert  = accept && (req.opcode == OP_INSERT) && !full;
        ctl.rotate  = (state_reg == ST_SCAN);
        load_now    = accept && !scan_op;
        load_finish = (state_reg == ST_FINISH) && out_free;
    end

    // After the given number of rotations the head cell holds that entry.
    assign step_live = (CNT_BITS'(step_reg) < count_reg);

    always_comb
    begin
        step_next    = step_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        rd_key_next  = rd_key_reg;
        rd_word_next = rd_word_reg;

        if (accept)
        begin
            op_next      = req.opcode;
            key_next     = req.row_key;
            pos_next     = req.position;
            hit_next     = 1'b0;
            rd_key_next  = '0;
            rd_word_next = '0;
            step_next    = '0;
            if (req.opcode == OP_INSERT && !full)
                count_next = count_reg + CNT_BITS'(1);
            else if (req.opcode == OP_CLEAR)
                count_next = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            step_next = step_reg + POS_BITS'(1);
            if (op_reg == OP_LOOKUP && step_live && head_key == key_reg)
                hit_next = 1'b1;
            if (op_reg == OP_READ && step_live && step_reg == pos_reg)
            begin
                rd_key_next  = head_key;
                rd_word_next = head_word;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_key_next   = out_key_reg;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (load_now)
        begin
            out_valid_next = 1'b1;
            out_found_next = 1'b0;
            out_key_next   = '0;
            out_word_next  = '0;
            out_count_next = count_next;
            out_ovf_next   = (req.opcode == OP_INSERT) && full;
        end
        else if (load_finish)
        begin
            out_valid_next = 1'b1;
            out_found_next = hit_reg;
            out_key_next   = rd_key_reg;
            out_word_next  = rd_word_reg;
            out_count_next = count_reg;
            out_ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        hit_reg       <= hit_next;
        rd_key_reg    <= rd_key_next;
        rd_word_reg   <= rd_word_next;
        out_found_reg <= out_found_next;
        out_key_reg   <= out_key_next;
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_key   = out_key_reg;
    assign rsp.entry_word  = out_word_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.overflow    = out_ovf_reg;
    assign count           = count_reg;

endmodule

/* rtl/sorted_key_value_table_core.sv */
// Sorted key/value table core: a row of entry cells kept in ascending key order.
// An insert or a clear completes on acceptance, and the next request is accepted
// as soon as the response register is free; the chain compares every cell at once
// and shifts the greater entries one place along. A lookup or a read rotates the
// cell ring once round, one place a cycle, past the head cell, and occupies the
// block until its response is registered. Depends on skvt_pkg, skvt_if, skvt_cell,
// skvt_ctrl and sorted_key_value_table_core_assert.svh.
`include "sorted_key_value_table_core_assert.svh"

module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    skvt_req_if.sink    req,
    skvt_rsp_if.source  rsp
);

    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(TABLE_DEPTH);

    cell_ctrl_t           ctl;
    logic [CNT_BITS-1:0]  count;
    logic                 cell_sel  [TABLE_DEPTH];
    logic [KEY_BITS-1:0]  cell_key  [TABLE_DEPTH];
    logic [WORD_BITS-1:0] cell_word [TABLE_DEPTH];

    skvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .head_key  (cell_key[0]),
        .head_word (cell_word[0]),
        .ctl       (ctl),
        .count     (count)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == TABLE_DEPTH - 1) ? 0 : i + 1;

        logic occ;
        logic tail;
        logic left_sel;

        assign occ      = (CNT_BITS'(i) < count);
        assign tail     = (CNT_BITS'(i) == count);
        assign left_sel = (i == 0) ? 1'b0 : cell_sel[PREV];

        skvt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occ        (occ),
            .tail       (tail),
            .new_key    (req.row_key),
            .new_word   (req.data_word),
            .left_sel   (left_sel),
            .left_key   (cell_key[PREV]),
            .left_word  (cell_word[PREV]),
            .right_key  (cell_key[NEXT]),
            .right_word (cell_word[NEXT]),
            .sel        (cell_sel[i]),
            .key        (cell_key[i]),
            .word       (cell_word[i])
        );
    end

    `SKVT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count <= FULL_CNT)
    `SKVT_ASSERT_NEXT(a_insert_grows, clk, rst_n,
        req.valid && req.ready && req.opcode == OP_INSERT && count != FULL_CNT,
        count == $past(count) + CNT_BITS'(1))
    `SKVT_ASSERT_NEXT(a_clear_empties, clk, rst_n,
        req.valid && req.ready && req.opcode == OP_CLEAR, count == '0)
    `SKVT_ASSERT_NOW(a_overflow_full, clk, rst_n,
        rsp.valid && rsp.overflow, rsp.entry_count == FULL_CNT)

endmodule
